### rtl/swr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swr_pkg: shared types and microcode for the square window rotator
// Control word layout, step codes, operation and jump codes, command codes,
// the microprogram and the dispatch table.
// ----------------------------------------------------------------------------
package swr_pkg;

    localparam int STEP_W = 4;
    localparam int WIN_W  = 5;
    localparam int WORD_W = 11;

    localparam logic [STEP_W-1:0] S_IDLE    = 4'd0;
    localparam logic [STEP_W-1:0] S_FILL    = 4'd1;
    localparam logic [STEP_W-1:0] S_GATHER  = 4'd2;
    localparam logic [STEP_W-1:0] S_GTAIL   = 4'd3;
    localparam logic [STEP_W-1:0] S_SCATTER = 4'd4;
    localparam logic [STEP_W-1:0] S_STAIL   = 4'd5;
    localparam logic [STEP_W-1:0] S_RD_ADDR = 4'd6;
    localparam logic [STEP_W-1:0] S_RD_OUT  = 4'd7;
    localparam logic [STEP_W-1:0] S_DONE    = 4'd8;
    localparam logic [STEP_W-1:0] S_BOOT    = 4'd9;

    localparam logic [2:0] OP_NOP     = 3'd0;
    localparam logic [2:0] OP_FILL    = 3'd1;
    localparam logic [2:0] OP_GATHER  = 3'd2;
    localparam logic [2:0] OP_SCATTER = 3'd3;
    localparam logic [2:0] OP_RD_ADDR = 3'd4;
    localparam logic [2:0] OP_RD_OUT  = 3'd5;

    localparam logic [1:0] JC_ALWAYS   = 2'd0;
    localparam logic [1:0] JC_LOOP     = 2'd1;
    localparam logic [1:0] JC_DISPATCH = 2'd2;

    localparam logic [1:0] CMD_ROT  = 2'd0;
    localparam logic [1:0] CMD_READ = 2'd1;
    localparam logic [1:0] CMD_INIT = 2'd2;

    localparam logic [1:0] CL_ROT  = 2'd0;
    localparam logic [1:0] CL_READ = 2'd1;
    localparam logic [1:0] CL_FILL = 2'd2;
    localparam logic [1:0] CL_BAD  = 2'd3;

    typedef struct packed {
        logic [2:0]        op;
        logic              emit;
        logic [1:0]        cond;
        logic [STEP_W-1:0] target;
    } uword_t;

    typedef struct packed {
        logic [2:0] op;
        logic       emit;
        logic       accept;
    } ctl_t;

    typedef struct packed {
        logic       last;
        logic [1:0] cls;
    } dp_stat_t;

    function automatic uword_t urom(input logic [STEP_W-1:0] step);
        uword_t w;
        w = '{op: OP_NOP, emit: 1'b0, cond: JC_ALWAYS, target: S_IDLE};
        unique case (step)
            S_IDLE:    w = '{op: OP_NOP,     emit: 1'b0, cond: JC_DISPATCH, target: S_IDLE};
            S_FILL:    w = '{op: OP_FILL,    emit: 1'b0, cond: JC_LOOP,     target: S_DONE};
            S_GATHER:  w = '{op: OP_GATHER,  emit: 1'b0, cond: JC_LOOP,     target: S_GTAIL};
            S_GTAIL:   w = '{op: OP_NOP,     emit: 1'b0, cond: JC_ALWAYS,   target: S_SCATTER};
            S_SCATTER: w = '{op: OP_SCATTER, emit: 1'b0, cond: JC_LOOP,     target: S_STAIL};
            S_STAIL:   w = '{op: OP_NOP,     emit: 1'b0, cond: JC_ALWAYS,   target: S_DONE};
            S_RD_ADDR: w = '{op: OP_RD_ADDR, emit: 1'b0, cond: JC_ALWAYS,   target: S_RD_OUT};
            S_RD_OUT:  w = '{op: OP_RD_OUT,  emit: 1'b1, cond: JC_ALWAYS,   target: S_IDLE};
            S_DONE:    w = '{op: OP_NOP,     emit: 1'b1, cond: JC_ALWAYS,   target: S_IDLE};
            S_BOOT:    w = '{op: OP_FILL,    emit: 1'b0, cond: JC_LOOP,     target: S_IDLE};
            default:   w = '{op: OP_NOP,     emit: 1'b0, cond: JC_ALWAYS,   target: S_IDLE};
        endcase
        return w;
    endfunction

    function automatic logic [STEP_W-1:0] dispatch(input logic [1:0] cls);
        logic [STEP_W-1:0] s;
        s = S_DONE;
        unique case (cls)
            CL_ROT:  s = S_GATHER;
            CL_READ: s = S_RD_ADDR;
            CL_FILL: s = S_FILL;
            CL_BAD:  s = S_DONE;
            default: s = S_DONE;
        endcase
        return s;
    endfunction

endpackage

### rtl/swr_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swr_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module swr_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### rtl/swr_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swr_seq: microcode sequencer
// Step counter over the control store, with loop and dispatch jumps.
// ----------------------------------------------------------------------------
module swr_seq
    import swr_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  dp_stat_t stat,
    output ctl_t     ctl,
    output logic     busy
);

    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    uword_t            uw;

    assign uw         = urom(step_reg);
    assign busy       = (step_reg != S_IDLE);
    assign ctl.op     = uw.op;
    assign ctl.emit   = uw.emit;
    assign ctl.accept = (uw.cond == JC_DISPATCH) && start;

    always_comb
    begin
        step_next = step_reg;
        unique case (uw.cond)
            JC_ALWAYS:   step_next = uw.target;
            JC_LOOP:     step_next = stat.last ? uw.target : step_reg;
            JC_DISPATCH: step_next = start ? dispatch(stat.cls) : step_reg;
            default:     step_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_BOOT;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

endmodule

### rtl/swr_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swr_dp: grid datapath
// Grid and scratch RAMs, window and fill counters, address generation,
// request checks and the result register.
// ----------------------------------------------------------------------------
module swr_dp
    import swr_pkg::*;
#(
    parameter int MAX_SIDE = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  ctl_t              ctl,
    input  logic [5:0]        matrix_size,
    input  logic [1:0]        command,
    input  logic [4:0]        row,
    input  logic [4:0]        col,
    input  logic [3:0]        radius,
    input  logic              direction,
    output dp_stat_t          stat,
    output logic [WORD_W-1:0] value,
    output logic              status,
    output logic              done
);

    localparam int IDX_W = $clog2(MAX_SIDE);
    localparam int AW    = 2 * IDX_W;
    localparam int DEPTH = 1 << AW;
    localparam int SZ_W  = $clog2(MAX_SIDE + 1);
    localparam int CW    = SZ_W + 7;
    localparam int SAW   = 2 * WIN_W;
    localparam int SDEPTH = 1 << SAW;
    localparam int BOOT_SZ = (MAX_SIDE < 32) ? MAX_SIDE : 32;

    logic [SZ_W-1:0]   eff_sz;
    logic              rot_ok;
    logic              rd_ok;
    logic [1:0]        cls;

    logic [SZ_W-1:0]   sz_reg;
    logic [4:0]        row_reg;
    logic [4:0]        col_reg;
    logic [WIN_W-1:0]  lim_reg;
    logic              dir_reg;
    logic              bad_reg;

    logic [WIN_W-1:0]  wi_reg;
    logic [WIN_W-1:0]  wj_reg;
    logic              win_last;
    logic [IDX_W-1:0]  fr_reg;
    logic [IDX_W-1:0]  fc_reg;
    logic [WORD_W-1:0] fv_reg;
    logic              fill_last;
    logic              fill_in;

    logic [4:0]        r0;
    logic [4:0]        c0;
    logic [AW-1:0]     win_addr;
    logic [AW-1:0]     cell_addr;
    logic [AW-1:0]     fill_addr;
    logic [SAW-1:0]    scr_waddr;
    logic [SAW-1:0]    scr_raddr;

    logic              sw_valid_reg;
    logic [SAW-1:0]    sw_addr_reg;
    logic              gw_valid_reg;
    logic [AW-1:0]     gw_addr_reg;

    logic              g_we;
    logic [AW-1:0]     g_waddr;
    logic [WORD_W-1:0] g_wdata;
    logic [AW-1:0]     g_raddr;
    logic [WORD_W-1:0] g_rdata;
    logic [WORD_W-1:0] s_rdata;

    logic              done_reg;
    logic [WORD_W-1:0] value_reg;
    logic              status_reg;

    logic              is_win;

    always_comb
    begin
        if (matrix_size == 6'd0)
        begin
            eff_sz = SZ_W'(1);
        end
        else if (CW'(matrix_size) > CW'(MAX_SIDE))
        begin
            eff_sz = SZ_W'(MAX_SIDE);
        end
        else
        begin
            eff_sz = SZ_W'(matrix_size);
        end
    end

    assign rot_ok = (row >= 5'(radius)) && (col >= 5'(radius))
                 && (CW'(row) + CW'(radius) < CW'(eff_sz))
                 && (CW'(col) + CW'(radius) < CW'(eff_sz));
    assign rd_ok  = (CW'(row) < CW'(eff_sz)) && (CW'(col) < CW'(eff_sz));

    always_comb
    begin
        unique case (command)
            CMD_ROT:  cls = rot_ok ? CL_ROT : CL_BAD;
            CMD_READ: cls = rd_ok ? CL_READ : CL_BAD;
            CMD_INIT: cls = CL_FILL;
            default:  cls = CL_BAD;
        endcase
    end

    assign win_last  = (wi_reg == lim_reg) && (wj_reg == lim_reg);
    assign fill_last = (fr_reg == IDX_W'(MAX_SIDE - 1)) && (fc_reg == IDX_W'(MAX_SIDE - 1));
    assign fill_in   = (CW'(fr_reg) < CW'(sz_reg)) && (CW'(fc_reg) < CW'(sz_reg));
    assign is_win    = (ctl.op == OP_GATHER) || (ctl.op == OP_SCATTER);

    assign stat.cls  = cls;
    assign stat.last = (ctl.op == OP_FILL) ? fill_last : win_last;

    assign r0        = row_reg - 5'(lim_reg >> 1);
    assign c0        = col_reg - 5'(lim_reg >> 1);
    assign win_addr  = {IDX_W'(r0 + wi_reg), IDX_W'(c0 + wj_reg)};
    assign cell_addr = {IDX_W'(row_reg), IDX_W'(col_reg)};
    assign fill_addr = {fr_reg, fc_reg};
    assign scr_raddr = {wi_reg, wj_reg};
    assign scr_waddr = dir_reg ? {lim_reg - wj_reg, wi_reg} : {wj_reg, lim_reg - wi_reg};

    assign g_raddr = (ctl.op == OP_RD_ADDR) ? cell_addr : win_addr;
    assign g_we    = (ctl.op == OP_FILL) || gw_valid_reg;
    assign g_waddr = (ctl.op == OP_FILL) ? fill_addr : gw_addr_reg;
    assign g_wdata = (ctl.op == OP_FILL) ? (fill_in ? fv_reg : '0) : s_rdata;

    swr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (DEPTH)
    ) u_grid (
        .clk   (clk),
        .we    (g_we),
        .waddr (g_waddr),
        .wdata (g_wdata),
        .raddr (g_raddr),
        .rdata (g_rdata)
    );

    swr_ram #(
        .WIDTH (WORD_W),
        .DEPTH (SDEPTH)
    ) u_scratch (
        .clk   (clk),
        .we    (sw_valid_reg),
        .waddr (sw_addr_reg),
        .wdata (g_rdata),
        .raddr (scr_raddr),
        .rdata (s_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sz_reg       <= SZ_W'(BOOT_SZ);
            bad_reg      <= 1'b0;
            wi_reg       <= '0;
            wj_reg       <= '0;
            fr_reg       <= '0;
            fc_reg       <= '0;
            fv_reg       <= WORD_W'(1);
            sw_valid_reg <= 1'b0;
            gw_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            sw_valid_reg <= (ctl.op == OP_GATHER);
            gw_valid_reg <= (ctl.op == OP_SCATTER);
            done_reg     <= ctl.emit;
            if (ctl.accept)
            begin
                sz_reg  <= eff_sz;
                bad_reg <= (cls == CL_BAD);
            end
            if (is_win)
            begin
                if (win_last)
                begin
                    wi_reg <= '0;
                    wj_reg <= '0;
                end
                else if (wj_reg == lim_reg)
                begin
                    wj_reg <= '0;
                    wi_reg <= wi_reg + 1'b1;
                end
                else
                begin
                    wj_reg <= wj_reg + 1'b1;
                end
            end
            if (ctl.op == OP_FILL)
            begin
                if (fill_last)
                begin
                    fr_reg <= '0;
                    fc_reg <= '0;
                    fv_reg <= WORD_W'(1);
                end
                else
                begin
                    if (fc_reg == IDX_W'(MAX_SIDE - 1))
                    begin
                        fc_reg <= '0;
                        fr_reg <= fr_reg + 1'b1;
                    end
                    else
                    begin
                        fc_reg <= fc_reg + 1'b1;
                    end
                    if (fill_in)
                    begin
                        fv_reg <= fv_reg + 1'b1;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.accept)
        begin
            row_reg <= row;
            col_reg <= col;
            lim_reg <= {radius, 1'b0};
            dir_reg <= direction;
        end
        sw_addr_reg <= scr_waddr;
        gw_addr_reg <= win_addr;
        if (ctl.emit)
        begin
            value_reg  <= (ctl.op == OP_RD_OUT) ? g_rdata : '0;
            status_reg <= (ctl.op == OP_RD_OUT) ? 1'b0 : bad_reg;
        end
    end

    assign value  = value_reg;
    assign status = status_reg;
    assign done   = done_reg;

    a_fill_no_scatter: assert property (@(posedge clk) disable iff (!rst_n)
        (ctl.op == OP_FILL) |-> !gw_valid_reg)
        else $error("fill write collides with scatter write");

    a_accept_drained: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.accept |-> (!sw_valid_reg && !gw_valid_reg))
        else $error("transaction accepted with RAM writes pending");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe held longer than one cycle");

    a_win_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.accept |-> (wi_reg == '0) && (wj_reg == '0))
        else $error("window counters not rewound");

endmodule

### rtl/square_window_rotate_90_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// square_window_rotate_90_top: square grid with in-place 90 degree rotation
// A rotation copies the window (side is 2*radius+1) to a scratch RAM and
// back, with one grid RAM access per cell in each of its two passes; reinit
// writes all MAX_SIDE*MAX_SIDE cells; reads and rejected requests skip both.
// One transaction at a time; busy stays high until the result is issued.
// After reset the grid is numbered in a pass over all MAX_SIDE*MAX_SIDE
// cells with busy high. The result strobe cannot be stalled.
// ----------------------------------------------------------------------------
module square_window_rotate_90_top
    import swr_pkg::*;
#(
    parameter int MAX_SIDE = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [1:0]        command,
    input  logic [4:0]        row,
    input  logic [4:0]        col,
    input  logic [3:0]        radius,
    input  logic              direction,
    output logic              done,
    output logic [WORD_W-1:0] value,
    output logic              status,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [5:0]        cfg_data
);

    logic [5:0] size_reg;
    ctl_t       ctl;
    dp_stat_t   stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= 6'd32;
        end
        else if (cfg_valid && cfg_ready)
        begin
            size_reg <= cfg_data;
        end
    end

    swr_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy)
    );

    swr_dp #(
        .MAX_SIDE (MAX_SIDE)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .matrix_size (size_reg),
        .command     (command),
        .row         (row),
        .col         (col),
        .radius      (radius),
        .direction   (direction),
        .stat        (stat),
        .value       (value),
        .status      (status),
        .done        (done)
    );

endmodule
